// File: src/salru_pkg.sv
`timescale 1ns / 1ps

package salru_pkg;

  localparam int unsigned DEF_MAX_WAYS = 8;
  localparam int unsigned DEF_MAX_SETS = 64;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned RANK_W    = 3;
  localparam int unsigned SET_BITS_W = 3;
  localparam int unsigned BLK_BITS_W = 6;
  localparam int unsigned WAYS_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned CNT_W     = 32;

  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd4;
  localparam logic [BLK_BITS_W-1:0] BLK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } out_t;

endpackage

// File: src/salru_set_mem.sv
`timescale 1ns / 1ps

module salru_set_mem #(
  parameter int unsigned MAX_WAYS = salru_pkg::DEF_MAX_WAYS,
  parameter int unsigned MAX_SETS = salru_pkg::DEF_MAX_SETS,
  parameter int unsigned SET_AW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [SET_AW-1:0]                 waddr_i,
  input  salru_pkg::line_t [MAX_WAYS-1:0]   wdata_i,
  input  logic                              re_i,
  input  logic [SET_AW-1:0]                 raddr_i,
  output salru_pkg::line_t [MAX_WAYS-1:0]   rdata_o
);
  import salru_pkg::*;

  line_t [MAX_WAYS-1:0] mem_q [MAX_SETS];
  line_t [MAX_WAYS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/salru_update.sv
`timescale 1ns / 1ps

module salru_update #(
  parameter int unsigned MAX_WAYS = salru_pkg::DEF_MAX_WAYS
) (
  input  salru_pkg::line_t [MAX_WAYS-1:0]      row_i,
  input  logic [salru_pkg::ADDR_W-1:0]         tag_i,
  input  logic [salru_pkg::WAYS_W-1:0]         ways_i,
  output salru_pkg::line_t [MAX_WAYS-1:0]      row_o,
  output salru_pkg::outcome_e                  outcome_o
);
  import salru_pkg::*;

  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0] use_w;
  logic [MAX_WAYS-1:0] match_w;
  logic [MAX_WAYS-1:0] empty_w;
  logic [MAX_WAYS-1:0] age_w;
  logic                hit;
  logic                has_empty;
  logic                age_all;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    empty_way;
  logic [WAY_W-1:0]    victim_way;
  logic [WAY_W-1:0]    sel_way;
  logic [RANK_W-1:0]   best_rank;
  logic [RANK_W-1:0]   limit;

  // ways past the configured count or MAX_WAYS never take part, but way 0 always does
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      use_w[w]   = (w == 0) || (WAYS_W'(w) < ways_i);
      match_w[w] = use_w[w] && row_i[w].valid && (row_i[w].tag == tag_i);
      empty_w[w] = use_w[w] && !row_i[w].valid;
    end
    hit       = |match_w;
    has_empty = |empty_w;
  end

  // lowest index wins in every search
  always_comb begin
    hit_way    = '0;
    empty_way  = '0;
    victim_way = '0;
    best_rank  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (use_w[w] && (row_i[w].rank > best_rank)) begin
        best_rank = row_i[w].rank;
      end
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match_w[w]) begin
        hit_way = WAY_W'(w);
      end
      if (empty_w[w]) begin
        empty_way = WAY_W'(w);
      end
      if (use_w[w] && (row_i[w].rank == best_rank)) begin
        victim_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    priority if (hit) begin
      sel_way   = hit_way;
      limit     = row_i[hit_way].rank;
      age_all   = 1'b0;
      outcome_o = OUT_HIT;
    end else if (has_empty) begin
      sel_way   = empty_way;
      limit     = '0;
      age_all   = 1'b1;
      outcome_o = OUT_FILL;
    end else begin
      sel_way   = victim_way;
      limit     = best_rank;
      age_all   = 1'b0;
      outcome_o = OUT_EVICT;
    end
  end

  always_comb begin
    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      age_w[w] = use_w[w] && row_i[w].valid && (age_all || (row_i[w].rank < limit))
                 && (row_i[w].rank != RANK_MAX);
      if (age_w[w]) begin
        row_o[w].rank = row_i[w].rank + RANK_W'(1);
      end
    end
    row_o[sel_way].valid = 1'b1;
    row_o[sel_way].tag   = tag_i;
    row_o[sel_way].rank  = '0;
  end

endmodule

// File: src/set_assoc_cache_lru_lookup_unit.sv
`timescale 1ns / 1ps

// Set-associative cache lookup with LRU replacement. Each accepted transaction reads the
// whole set row (all ways: valid, tag, rank) from a synchronous registered-read memory,
// compares every way in parallel in the next cycle, writes the updated row back and
// loads the result register. The block takes no new item until the current one has
// written back. A result that is not taken holds the next item in its compare cycle.
// After reset the block runs a clearing pass over every set of the set memory, during
// which input transactions are stalled; configuration writes are taken at any time.
module set_assoc_cache_lru_lookup_unit #(
  parameter int unsigned MAX_WAYS = salru_pkg::DEF_MAX_WAYS,
  parameter int unsigned MAX_SETS = salru_pkg::DEF_MAX_SETS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [salru_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  salru_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output salru_pkg::out_t                   out_data_o
);
  import salru_pkg::*;

  localparam int unsigned SET_AW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned SET_LOG = $clog2(MAX_SETS + 1) - 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [SET_BITS_W-1:0] set_bits_q;
  logic [BLK_BITS_W-1:0] block_bits_q;
  logic [WAYS_W-1:0]     ways_q;

  logic [SET_AW-1:0]     clr_q;
  logic [SET_AW-1:0]     set_q;
  logic [ADDR_W-1:0]     tag_q;
  logic                  kind_q;

  logic [CNT_W-1:0]      hit_q, miss_q, evict_q;
  logic [CNT_W-1:0]      hit_d, miss_d, evict_d;
  logic                  out_valid_q;
  out_t                  out_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  look_done;
  logic [SET_BITS_W-1:0] sb_eff;
  logic [6:0]            tshift;
  logic [ADDR_W-1:0]     set_full;
  logic [SET_AW-1:0]     set_idx;
  logic [ADDR_W-1:0]     tag_new;

  logic                  mem_we;
  logic [SET_AW-1:0]     mem_waddr;
  line_t [MAX_WAYS-1:0]  mem_wdata;
  line_t [MAX_WAYS-1:0]  mem_rdata;
  line_t [MAX_WAYS-1:0]  upd_row;
  outcome_e              upd_outcome;

  logic [1:0]            hit_inc;
  logic [CNT_W:0]        hit_sum, miss_sum, evict_sum;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= SET_BITS_RST;
      block_bits_q <= BLK_BITS_RST;
      ways_q       <= WAYS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i[BLK_BITS_W-1:0];
        CFG_WAYS:       ways_q       <= cfg_wdata_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    sb_eff   = (int'(set_bits_q) > SET_LOG) ? SET_BITS_W'(SET_LOG) : set_bits_q;
    tshift   = {1'b0, block_bits_q} + {4'b0, sb_eff};
    set_full = (in_data_i.address >> block_bits_q) & ((64'd1 << sb_eff) - 64'd1);
    set_idx  = set_full[SET_AW-1:0];
    tag_new  = tshift[6] ? '0 : (in_data_i.address >> tshift[5:0]);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign look_done  = (state_q == ST_LOOK) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == SET_AW'(MAX_SETS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_LOOK;
      ST_LOOK:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + SET_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q  <= set_idx;
      tag_q  <= tag_new;
      kind_q <= in_data_i.kind;
    end
  end

  // clearing pass writes empty rows, a lookup writes back its updated row
  always_comb begin
    mem_we    = (state_q == ST_CLEAR) || look_done;
    mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_q;
    mem_wdata = (state_q == ST_CLEAR) ? '0 : upd_row;
  end

  salru_set_mem #(
    .MAX_WAYS (MAX_WAYS),
    .MAX_SETS (MAX_SETS),
    .SET_AW   (SET_AW)
  ) u_set_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (set_idx),
    .rdata_o (mem_rdata)
  );

  salru_update #(
    .MAX_WAYS (MAX_WAYS)
  ) u_update (
    .row_i     (mem_rdata),
    .tag_i     (tag_q),
    .ways_i    (ways_q),
    .row_o     (upd_row),
    .outcome_o (upd_outcome)
  );

  // the repeat access of a modify always hits the line just touched
  always_comb begin
    hit_inc   = {1'b0, (upd_outcome == OUT_HIT)} + {1'b0, kind_q};
    hit_sum   = {1'b0, hit_q} + (CNT_W + 1)'(hit_inc);
    miss_sum  = {1'b0, miss_q} + (CNT_W + 1)'(upd_outcome != OUT_HIT);
    evict_sum = {1'b0, evict_q} + (CNT_W + 1)'(upd_outcome == OUT_EVICT);
    hit_d     = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    miss_d    = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
    evict_d   = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (look_done) begin
        hit_q       <= hit_d;
        miss_q      <= miss_d;
        evict_q     <= evict_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_done) begin
      out_q.outcome     <= upd_outcome;
      out_q.extra_hit   <= kind_q;
      out_q.hit_total   <= hit_d;
      out_q.miss_total  <= miss_d;
      out_q.evict_total <= evict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.evict_total <= out_data_o.miss_total))
    else $error("eviction total above miss total");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.outcome != 2'd3))
    else $error("illegal outcome code");

  a_look_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    look_done |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished lookup did not load the result register");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != ST_IDLE))
    else $error("set memory written while idle");

  a_counters_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !look_done |=> ($stable(hit_q) && $stable(miss_q) && $stable(evict_q)))
    else $error("totals changed outside a lookup");

endmodule
